FILE: src/sra_pkg.sv
// Shared constants and types for the stack region allocator.
package sra_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ALIGN_BYTES = 32;

    localparam int STACK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W    = $clog2(STACK_DEPTH + 1);

    localparam int ADDR_W   = 26;
    localparam int BASE_W   = 25;
    localparam int LIMIT_W  = 7;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;

    localparam logic [BASE_W-1:0]  BASE_RESET  = BASE_W'(32'h0000_4000);
    localparam logic [ADDR_W-1:0]  END_RESET   = ADDR_W'(32'd16 * 32'd1024 * 32'd1024);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_OFF     = 3'd1,
        ST_BADLEN  = 3'd2,
        ST_FULL    = 3'd3,
        ST_NOROOM  = 3'd4,
        ST_UNDER   = 3'd5,
        ST_CORRUPT = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLED     = 2'd0,
        REG_ARENA_BASE  = 2'd1,
        REG_ARENA_END   = 2'd2,
        REG_ENTRY_LIMIT = 2'd3
    } t_reg_idx;

endpackage

FILE: src/sra_ifs.sv
// Channel interfaces: request, response and configuration write.
interface sra_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [sra_pkg::ADDR_W-1:0]    request_length;

    modport source (output valid, command, request_length, input ready);
    modport sink   (input valid, command, request_length, output ready);
endinterface

interface sra_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sra_pkg::ADDR_W-1:0]    address;
    logic [sra_pkg::ADDR_W-1:0]    released_length;
    logic [sra_pkg::STATUS_W-1:0]  status;

    modport source (output valid, address, released_length, status, input ready);
    modport sink   (input valid, address, released_length, status, output ready);
endinterface

interface sra_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sra_pkg::CFG_IDX_W-1:0]   index;
    logic [sra_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/sra_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/stack_region_allocator_unit.sv
// Stack region allocator top level: LIFO region allocation over a length stack in RAM.
//
//  channel | modport | transaction carries
//  i_req   | sink    | command, request_length
//  o_rsp   | source  | address, released_length, status
//  i_cfg   | sink    | index, data (register write)
//
// A request is accepted in S_IDLE during the length-stack RAM read; S_EXEC
// then checks, updates state and writes the RAM back. One request is in flight at a time.
// Synchronous active-low reset; the length stack holds no reset value.
// A finished response waits in the output register; a new request is taken
// while it waits, and stalls in S_EXEC only if the register is full and not being read.
// A pending register write holds off the request channel for that cycle.
module stack_region_allocator_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sra_req_if.sink      i_req,
    sra_rsp_if.source    o_rsp,
    sra_cfg_if.sink      i_cfg
);

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    localparam int AW  = sra_pkg::ADDR_W;
    localparam int SAW = sra_pkg::STACK_AW;
    localparam int CW  = sra_pkg::CNT_W;

    t_state                        r_state;
    logic                          r_enabled;
    logic [sra_pkg::BASE_W-1:0]    r_base;
    logic [AW-1:0]                 r_end;
    logic [sra_pkg::LIMIT_W-1:0]   r_limit;
    logic [AW-1:0]                 r_top;
    logic [CW-1:0]                 r_used;
    sra_pkg::t_cmd                 r_cmd;
    logic [AW-1:0]                 r_len;

    logic                          r_out_valid;
    logic [AW-1:0]                 r_out_addr;
    logic [AW-1:0]                 r_out_rel;
    sra_pkg::t_status              r_out_status;

    logic                          req_acc;
    logic                          cfg_acc;
    logic                          slot_free;
    logic                          finish;
    logic [AW-1:0]                 rd_len;
    logic [AW-1:0]                 base_ext;
    logic [AW-1:0]                 used_space;
    logic [AW-1:0]                 room;
    logic                          lim_below;
    logic                          full;
    sra_pkg::t_status              res_status;
    logic [AW-1:0]                 res_addr;
    logic [AW-1:0]                 res_rel;
    logic                          push_ok;
    logic                          pop_ok;
    logic [SAW-1:0]                rd_addr;

    assign i_req.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign finish      = (r_state == S_EXEC) && slot_free;

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.address         = r_out_addr;
    assign o_rsp.released_length = r_out_rel;
    assign o_rsp.status          = r_out_status;

    assign rd_addr = SAW'(r_used - CW'(1));

    sra_ram #(
        .WIDTH (AW),
        .DEPTH (sra_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (finish && push_ok),
        .i_waddr (SAW'(r_used)),
        .i_wdata (r_len),
        .i_raddr (rd_addr),
        .o_rdata (rd_len)
    );

    assign base_ext   = AW'(r_base);
    assign used_space = r_top - base_ext;
    assign room       = r_end - r_top;
    assign lim_below  = 32'(r_limit) < 32'(sra_pkg::STACK_DEPTH);
    assign full       = lim_below ? (32'(r_used) >= 32'(r_limit))
                                  : (32'(r_used) >= 32'(sra_pkg::STACK_DEPTH));

    always_comb begin
        res_status = sra_pkg::ST_OK;
        res_addr   = '0;
        res_rel    = '0;
        push_ok    = 1'b0;
        pop_ok     = 1'b0;
        if (!r_enabled) begin
            res_status = sra_pkg::ST_OFF;
        end else if (r_cmd == sra_pkg::CMD_ALLOC) begin
            if (r_len == '0 || (r_len % sra_pkg::ALIGN_BYTES) != '0) begin
                res_status = sra_pkg::ST_BADLEN;
            end else if (full) begin
                res_status = sra_pkg::ST_FULL;
            end else if (r_top > r_end || r_len > room) begin
                res_status = sra_pkg::ST_NOROOM;
            end else begin
                res_addr = r_top;
                push_ok  = 1'b1;
            end
        end else begin
            if (r_used == '0 || r_top <= base_ext) begin
                res_status = sra_pkg::ST_UNDER;
            end else if (rd_len > used_space) begin
                res_status = sra_pkg::ST_CORRUPT;
            end else begin
                res_addr = r_top - rd_len;
                res_rel  = rd_len;
                pop_ok   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_enabled    <= 1'b0;
            r_base       <= sra_pkg::BASE_RESET;
            r_end        <= sra_pkg::END_RESET;
            r_limit      <= sra_pkg::LIMIT_RESET;
            r_top        <= AW'(sra_pkg::BASE_RESET);
            r_used       <= '0;
            r_out_valid  <= 1'b0;
            r_out_status <= sra_pkg::ST_OK;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_acc) begin
                unique case (sra_pkg::t_reg_idx'(i_cfg.index))
                    sra_pkg::REG_ENABLED: begin
                        if (i_cfg.data[0] && !r_enabled) begin
                            r_top  <= base_ext;
                            r_used <= '0;
                        end
                        r_enabled <= i_cfg.data[0];
                    end
                    sra_pkg::REG_ARENA_BASE:  r_base  <= i_cfg.data[sra_pkg::BASE_W-1:0];
                    sra_pkg::REG_ARENA_END:   r_end   <= i_cfg.data[AW-1:0];
                    sra_pkg::REG_ENTRY_LIMIT: r_limit <= i_cfg.data[sra_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_cmd   <= sra_pkg::t_cmd'(i_req.command);
                        r_len   <= i_req.request_length;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_addr   <= res_addr;
                        r_out_rel    <= res_rel;
                        r_out_status <= res_status;
                        if (push_ok) begin
                            r_used <= r_used + CW'(1);
                            r_top  <= r_top + r_len;
                        end else if (pop_ok) begin
                            r_used <= r_used - CW'(1);
                            r_top  <= res_addr;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= 32'(sra_pkg::STACK_DEPTH))
        else $error("entry count beyond stack depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != sra_pkg::ST_OK) |->
            (r_out_addr == '0 && r_out_rel == '0))
        else $error("failed response carries nonzero payload");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !cfg_acc) |=> ($stable(r_used) && $stable(r_top)))
        else $error("allocator state changed without a transaction");

    a_free_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && pop_ok) |-> (rd_len != '0))
        else $error("popped a zero length");

endmodule

FILE: bench/tb_stack_region_allocator_unit.sv
// Self-checking testbench for the stack region allocator: directed table, then random phases.
module tb_stack_region_allocator_unit;
    import sra_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RAND_PHASES    = 13;
    localparam int PHASE_ITEMS    = 135;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] released;
        t_status           status;
    } rsp_t;

    typedef enum logic { ROW_CFG, ROW_REQ } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        t_reg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
        t_cmd                  cmd;
        logic [ADDR_W-1:0]     len;
        logic                  typed;
        rsp_t                  rsp;
    } plan_row_t;

    localparam int PLAN_ROWS = 52;

    // Expected responses are typed in only for rows whose outcome is obvious.
    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd32,      1'b1, '{26'h0, 26'h0, ST_OFF}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_FREE,  26'h3FFFFFF, 1'b1, '{26'h0, 26'h0, ST_OFF}},
        '{ROW_CFG, REG_ENABLED,     26'h1,       CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'h0,       1'b1, '{26'h0, 26'h0, ST_BADLEN}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'h3FFFFFF, 1'b1, '{26'h0, 26'h0, ST_BADLEN}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd31,      1'b1, '{26'h0, 26'h0, ST_BADLEN}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_FREE,  26'h0,       1'b1, '{26'h0, 26'h0, ST_UNDER}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd32,      1'b1, '{26'h4000, 26'h0, ST_OK}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'h3FFFFE0, 1'b1, '{26'h0, 26'h0, ST_NOROOM}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'h2000000, 1'b1, '{26'h0, 26'h0, ST_NOROOM}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_FREE,  26'h0,       1'b1, '{26'h4000, 26'd32, ST_OK}},
        '{ROW_CFG, REG_ENTRY_LIMIT, 26'd1,       CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd64,      1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd64,      1'b1, '{26'h0, 26'h0, ST_FULL}},
        '{ROW_CFG, REG_ENTRY_LIMIT, 26'd0,       CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd32,      1'b1, '{26'h0, 26'h0, ST_FULL}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_FREE,  26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd32,      1'b1, '{26'h0, 26'h0, ST_FULL}},
        '{ROW_CFG, REG_ENTRY_LIMIT, 26'd127,     CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd64,      1'b0, '0},
        '{ROW_CFG, REG_ARENA_BASE,  26'h4020,    CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_FREE,  26'h0,       1'b1, '{26'h0, 26'h0, ST_CORRUPT}},
        '{ROW_CFG, REG_ARENA_BASE,  26'h5000,    CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_FREE,  26'h0,       1'b1, '{26'h0, 26'h0, ST_UNDER}},
        '{ROW_CFG, REG_ARENA_BASE,  26'h4000,    CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_CFG, REG_ARENA_END,   26'h0,       CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd32,      1'b1, '{26'h0, 26'h0, ST_NOROOM}},
        '{ROW_CFG, REG_ARENA_END,   26'h3FFFFFF, CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_FREE,  26'h0,       1'b1, '{26'h4000, 26'd64, ST_OK}},
        '{ROW_CFG, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_FREE,  26'h0,       1'b1, '{26'h0, 26'h0, ST_OFF}},
        '{ROW_CFG, REG_ARENA_BASE,  26'h1FFFFE0, CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_CFG, REG_ARENA_END,   26'h2000000, CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_CFG, REG_ENABLED,     26'h1,       CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_CFG, REG_ENABLED,     26'h1,       CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd32,      1'b1, '{26'h1FFFFE0, 26'h0, ST_OK}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd32,      1'b1, '{26'h0, 26'h0, ST_NOROOM}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_FREE,  26'h0,       1'b1, '{26'h1FFFFE0, 26'd32, ST_OK}},
        '{ROW_CFG, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_CFG, REG_ARENA_BASE,  26'h1FFFFFF, CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_CFG, REG_ENABLED,     26'h1,       CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd32,      1'b1, '{26'h0, 26'h0, ST_NOROOM}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_FREE,  26'h0,       1'b1, '{26'h0, 26'h0, ST_UNDER}},
        '{ROW_CFG, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_CFG, REG_ARENA_BASE,  26'h0,       CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_CFG, REG_ENABLED,     26'h1,       CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'h2000000, 1'b1, '{26'h0, 26'h0, ST_OK}},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_FREE,  26'h0,       1'b1, '{26'h0, 26'h2000000, ST_OK}},
        '{ROW_CFG, REG_ENTRY_LIMIT, 26'd64,      CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_CFG, REG_ARENA_END,   26'h1000000, CMD_ALLOC, 26'h0,       1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_ALLOC, 26'd96,      1'b0, '0},
        '{ROW_REQ, REG_ENABLED,     26'h0,       CMD_FREE,  26'h0,       1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    sra_req_if req_ch ();
    sra_rsp_if rsp_ch ();
    sra_cfg_if cfg_ch ();

    stack_region_allocator_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // allocator shadow state
    logic                 shadow_enabled;
    logic [BASE_W-1:0]    shadow_base;
    logic [ADDR_W-1:0]    shadow_end;
    logic [LIMIT_W-1:0]   shadow_limit;
    logic [ADDR_W-1:0]    shadow_top;
    logic [CNT_W-1:0]     shadow_used;
    logic [ADDR_W-1:0]    shadow_lengths [STACK_DEPTH];

    rsp_t pending_rsp [$];

    logic  typed_flag;
    rsp_t  typed_rsp;
    int    idle_pct;
    int    error_cnt;
    int    hold_left;
    bit    hold_req;
    int    quiet_cnt;

    int                    row_i;
    int                    phase;
    int                    item_n;
    int                    phase_items;
    int                    alloc_pct;
    int                    pick;
    t_cmd                  rand_cmd;
    logic [ADDR_W-1:0]     rand_len;
    logic [BASE_W-1:0]     rand_base;
    logic [ADDR_W-1:0]     rand_end;
    logic [LIMIT_W-1:0]    rand_limit;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic rsp_t predict_allocation(input t_cmd cmd, input logic [ADDR_W-1:0] len);
        rsp_t              r;
        int unsigned       cap;
        logic [ADDR_W-1:0] rel;
        r = '0;
        r.status = ST_OK;
        if (!shadow_enabled) begin
            r.status = ST_OFF;
        end else if (cmd == CMD_ALLOC) begin
            cap = (shadow_limit < STACK_DEPTH) ? shadow_limit : STACK_DEPTH;
            if (len == '0 || (len % ALIGN_BYTES) != 0) begin
                r.status = ST_BADLEN;
            end else if (shadow_used >= cap) begin
                r.status = ST_FULL;
            end else if (shadow_top > shadow_end || len > shadow_end - shadow_top) begin
                r.status = ST_NOROOM;
            end else begin
                r.address = shadow_top;
                shadow_lengths[shadow_used % STACK_DEPTH] = len;
                shadow_used = shadow_used + 1'b1;
                shadow_top = shadow_top + len;
            end
        end else begin
            if (shadow_used == '0 || shadow_top <= {1'b0, shadow_base}) begin
                r.status = ST_UNDER;
            end else begin
                rel = shadow_lengths[(shadow_used - 1'b1) % STACK_DEPTH];
                if (rel > shadow_top - {1'b0, shadow_base}) begin
                    r.status = ST_CORRUPT;
                end else begin
                    shadow_used = shadow_used - 1'b1;
                    shadow_top = shadow_top - rel;
                    r.address = shadow_top;
                    r.released = rel;
                end
            end
        end
        return r;
    endfunction

    // Response checker and expectation store
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                if (error_cnt < 10)
                    $display("ERROR: response with nothing pending: addr=%h rel=%h st=%0d",
                             rsp_ch.address, rsp_ch.released_length, rsp_ch.status);
                error_cnt++;
            end else begin
                if (rsp_ch.address !== pending_rsp[0].address ||
                    rsp_ch.released_length !== pending_rsp[0].released ||
                    rsp_ch.status !== pending_rsp[0].status) begin
                    if (error_cnt < 10)
                        $display("ERROR: expected addr=%h rel=%h st=%0d, got addr=%h rel=%h st=%0d",
                                 pending_rsp[0].address, pending_rsp[0].released,
                                 pending_rsp[0].status, rsp_ch.address,
                                 rsp_ch.released_length, rsp_ch.status);
                    error_cnt++;
                end
                void'(pending_rsp.pop_front());
            end
        end
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            if (typed_flag) begin
                void'(predict_allocation(t_cmd'(req_ch.command), req_ch.request_length));
                pending_rsp.push_back(typed_rsp);
            end else begin
                pending_rsp.push_back(predict_allocation(t_cmd'(req_ch.command),
                                                         req_ch.request_length));
            end
        end
    end

    // Response side back-pressure
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("TIMEOUT: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    // Entered and left at a falling edge; lowers the request valid first.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic send_request(input t_cmd cmd, input logic [ADDR_W-1:0] len,
                                input logic typed, input rsp_t exp_rsp);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.request_length <= len;
        typed_flag            <= typed;
        typed_rsp             <= exp_rsp;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_ENABLED: begin
                if (value[0] && !shadow_enabled) begin
                    shadow_top  = {1'b0, shadow_base};
                    shadow_used = '0;
                end
                shadow_enabled = value[0];
            end
            REG_ARENA_BASE:  shadow_base  = value[BASE_W-1:0];
            REG_ARENA_END:   shadow_end   = value[ADDR_W-1:0];
            REG_ENTRY_LIMIT: shadow_limit = value[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_ALLOC;
        req_ch.request_length = '0;
        rsp_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_ENABLED;
        cfg_ch.data           = '0;
        typed_flag            = 1'b0;
        typed_rsp             = '0;
        idle_pct              = 16;
        error_cnt             = 0;
        hold_left             = 0;
        hold_req              = 1'b0;
        quiet_cnt             = 0;
        shadow_enabled        = 1'b0;
        shadow_base           = BASE_RESET;
        shadow_end            = END_RESET;
        shadow_limit          = LIMIT_RESET;
        shadow_top            = {1'b0, BASE_RESET};
        shadow_used           = '0;
        for (int k = 0; k < STACK_DEPTH; k++)
            shadow_lengths[k] = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (row_i = 0; row_i < PLAN_ROWS; row_i++) begin
            if (DIRECTED_PLAN[row_i].kind == ROW_CFG)
                write_reg(DIRECTED_PLAN[row_i].idx, DIRECTED_PLAN[row_i].data);
            else
                send_request(DIRECTED_PLAN[row_i].cmd, DIRECTED_PLAN[row_i].len,
                             DIRECTED_PLAN[row_i].typed, DIRECTED_PLAN[row_i].rsp);
        end

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            idle_pct = (phase == 7) ? 0 : 16;

            pick = $urandom_range(0, 7);
            if (pick == 0)      rand_base = '0;
            else if (pick == 1) rand_base = '1;
            else if (pick == 2) rand_base = BASE_W'($urandom);
            else                rand_base = BASE_W'(ALIGN_BYTES * $urandom_range(0, 2048));

            pick = $urandom_range(0, 9);
            if (pick == 0)      rand_end = '1;
            else if (pick == 1) rand_end = ADDR_W'(32'h200_0000);
            else if (pick == 2) rand_end = ADDR_W'($urandom);
            else if (pick == 3) rand_end = '0;
            else rand_end = ADDR_W'(rand_base) + ADDR_W'(ALIGN_BYTES * $urandom_range(0, 4096));

            pick = $urandom_range(0, 9);
            if (pick == 0)      rand_limit = '0;
            else if (pick == 1) rand_limit = 7'd1;
            else if (pick == 2) rand_limit = '1;
            else if (pick == 3) rand_limit = 7'd64;
            else                rand_limit = LIMIT_W'($urandom_range(1, 64));

            if ($urandom_range(0, 3) != 0) begin
                // fresh arena: disable, reprogram, re-enable
                write_reg(REG_ENABLED, {25'($urandom), 1'b0});
                write_reg(REG_ARENA_BASE, {1'($urandom), rand_base});
                write_reg(REG_ARENA_END, rand_end);
                write_reg(REG_ENTRY_LIMIT, {19'($urandom), rand_limit});
                write_reg(REG_ENABLED, {25'($urandom), 1'b1});
            end else begin
                // keep the stack, move the bounds under it
                pick = $urandom_range(0, 2);
                if (pick == 0)      write_reg(REG_ARENA_BASE, {1'b0, rand_base});
                else if (pick == 1) write_reg(REG_ARENA_END, rand_end);
                else                write_reg(REG_ENTRY_LIMIT, {19'd0, rand_limit});
                write_reg(REG_ENABLED, {25'($urandom), 1'b1});
            end

            phase_items = PHASE_ITEMS;
            if (phase == 10) begin
                write_reg(REG_ENABLED, '0);
                phase_items = 20;
            end

            if (phase == 2)
                hold_req = 1'b1;
            alloc_pct = $urandom_range(35, 75);

            for (item_n = 0; item_n < phase_items; item_n++) begin
                if (phase == 5 && item_n == 60)
                    wait_drained();
                rand_cmd = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
                pick = $urandom_range(0, 99);
                if (pick < 70)      rand_len = ADDR_W'(ALIGN_BYTES * $urandom_range(1, 32));
                else if (pick < 80) rand_len = ADDR_W'(ALIGN_BYTES * $urandom_range(1, 1 << 20));
                else if (pick < 88) rand_len = '0;
                else                rand_len = ADDR_W'($urandom);
                send_request(rand_cmd, rand_len, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (pending_rsp.size() != 0) begin
            if (error_cnt < 10)
                $display("ERROR: %0d responses never arrived", pending_rsp.size());
            error_cnt++;
        end

        if (error_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: stack_region_allocator_unit.f
src/sra_pkg.sv
src/sra_ifs.sv
src/sra_ram.sv
src/stack_region_allocator_unit.sv
bench/tb_stack_region_allocator_unit.sv
